// ===== src/pressure_temperature_depth_compensation_top_assert.svh =====
// ----------------------------------------------------------------------------
// pressure temperature depth compensation assertion macros
// concurrent checks, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_DEPTH_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMPERATURE_DEPTH_COMPENSATION_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PTDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptdc same-cycle check failed");
// next-cycle implication
`define PTDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptdc next-cycle check failed");
`else
`define PTDC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PTDC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ptdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdc_pkg
// types and constants shared by the compensation pipeline
// ----------------------------------------------------------------------------
package ptdc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam int QUOT_W     = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_C1   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_C2   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C3   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_C4   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_C5   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_C6   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SURF = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO  = 3'd7;

   localparam logic [17:0]        SURF_RESET    = 18'd101300;
   localparam logic [11:0]        RHO_RESET     = 12'd1029;
   localparam logic signed [19:0] TEMP_REF      = 20'sd2000;
   localparam logic signed [19:0] TEMP_VLOW_OFS = 20'sd1500;
   localparam logic signed [19:0] TEMP_VLOW_MAX = -20'sd1600;
   localparam logic [19:0]        GRAV_SCALE    = 20'd980665;
   localparam logic [26:0]        DEPTH_SCALE   = 27'd100000000;
   localparam logic [31:0]        RECIP_TEN     = 32'hCCCCCCCD;

   typedef struct packed {
      logic [23:0] raw_pressure_d1;
      logic [23:0] raw_temperature_d2;
   } req_type;

   typedef struct packed {
      logic signed [16:0] pressure_mbar;
      logic signed [15:0] temperature_centi;
      logic signed [23:0] depth_mm;
   } rsp_type;

   typedef struct packed {
      logic [15:0] coeff_sens_c1;
      logic [15:0] coeff_off_c2;
      logic [15:0] coeff_tcs_c3;
      logic [15:0] coeff_tco_c4;
      logic [15:0] coeff_tref_c5;
      logic [15:0] coeff_tsens_c6;
      logic [17:0] surface_pressure_pa;
      logic [11:0] fluid_density_kgm3;
   } cfg_type;

   // second-order corrected offset and sensitivity
   typedef struct packed {
      logic [23:0]        d1;
      logic signed [39:0] offs;
      logic signed [39:0] sens;
      logic signed [15:0] temp_sat;
   } comp_type;

   // pressure result and pascal excess over surface
   typedef struct packed {
      logic signed [35:0] excess_pa;
      logic signed [16:0] press_sat;
      logic signed [15:0] temp_sat;
   } press_type;

   // divider result
   typedef struct packed {
      logic [QUOT_W-1:0]  quot;
      logic               ovf;
      logic               neg;
      logic signed [16:0] press_sat;
      logic signed [15:0] temp_sat;
   } div_type;

endpackage

// ===== src/ptdc_front.sv =====
// ----------------------------------------------------------------------------
// ptdc_front
// first and second order temperature compensation, six stages
// ----------------------------------------------------------------------------
module ptdc_front import ptdc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_vld,
   input  req_type  in_data,
   input  cfg_type  cfg,
   output logic     out_vld,
   output comp_type out_data
);

   logic [5:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_vld};
      end
   end

   // stage 1: dT
   logic signed [24:0] s1_dt_in, s1_dt_ff;
   logic [23:0]        s1_d1_ff;

   assign s1_dt_in = $signed({1'b0, in_data.raw_temperature_d2})
                   - $signed({1'b0, cfg.coeff_tref_c5, 8'h00});

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dt_ff <= s1_dt_in;
         s1_d1_ff <= in_data.raw_pressure_d1;
      end
   end

   // stage 2: products with dT
   logic signed [41:0] s2_p6_in, s2_p4_in, s2_p3_in;
   logic signed [41:0] s2_p6_ff, s2_p4_ff, s2_p3_ff;
   logic signed [49:0] s2_dsq_in, s2_dsq_ff;
   logic [23:0]        s2_d1_ff;

   assign s2_p6_in  = s1_dt_ff * $signed({1'b0, cfg.coeff_tsens_c6});
   assign s2_p4_in  = s1_dt_ff * $signed({1'b0, cfg.coeff_tco_c4});
   assign s2_p3_in  = s1_dt_ff * $signed({1'b0, cfg.coeff_tcs_c3});
   assign s2_dsq_in = s1_dt_ff * s1_dt_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_p6_ff  <= s2_p6_in;
         s2_p4_ff  <= s2_p4_in;
         s2_p3_ff  <= s2_p3_in;
         s2_dsq_ff <= s2_dsq_in;
         s2_d1_ff  <= s1_d1_ff;
      end
   end

   // stage 3: TEMP, OFF, SENS and both Ti candidates
   logic signed [41:0] p6_adj, p4_adj, p3_adj;
   logic [49:0]        dsq_u;
   logic [50:0]        dsq3;
   logic signed [19:0] s3_temp_in, s3_temp_ff;
   logic signed [36:0] s3_offs_in, s3_offs_ff;
   logic signed [35:0] s3_sens_in, s3_sens_ff;
   logic [17:0]        s3_tilo_ff;
   logic [13:0]        s3_tihi_ff;
   logic [23:0]        s3_d1_ff;

   // truncation toward zero on arithmetic shifts
   assign p6_adj = s2_p6_ff + (s2_p6_ff[41] ? 42'sd8388607 : 42'sd0);
   assign p4_adj = s2_p4_ff + (s2_p4_ff[41] ? 42'sd127 : 42'sd0);
   assign p3_adj = s2_p3_ff + (s2_p3_ff[41] ? 42'sd255 : 42'sd0);
   assign dsq_u  = s2_dsq_ff;
   assign dsq3   = {1'b0, dsq_u} + {dsq_u, 1'b0};

   assign s3_temp_in = TEMP_REF + $signed(p6_adj[41:23]);
   assign s3_offs_in = $signed({5'b0, cfg.coeff_off_c2, 16'h0000}) + $signed(p4_adj[41:7]);
   assign s3_sens_in = $signed({5'b0, cfg.coeff_sens_c1, 15'h0000}) + $signed(p3_adj[41:8]);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_temp_ff <= s3_temp_in;
         s3_offs_ff <= s3_offs_in;
         s3_sens_ff <= s3_sens_in;
         s3_tilo_ff <= dsq3[50:33];
         s3_tihi_ff <= dsq_u[49:36];
         s3_d1_ff   <= s2_d1_ff;
      end
   end

   // stage 4: squares of deviation, branch flags, final temperature
   logic signed [19:0] dev, vofs;
   logic signed [39:0] s4_devsq_in, s4_devsq_ff, s4_vsq_in, s4_vsq_ff;
   logic               s4_low_in, s4_low_ff, s4_vlow_in, s4_vlow_ff;
   logic [17:0]        ti_sel;
   logic signed [20:0] t_full;
   logic signed [15:0] s4_tsat_in, s4_tsat_ff;
   logic signed [36:0] s4_offs_ff;
   logic signed [35:0] s4_sens_ff;
   logic [23:0]        s4_d1_ff;

   assign dev         = s3_temp_ff - TEMP_REF;
   assign vofs        = s3_temp_ff + TEMP_VLOW_OFS;
   assign s4_devsq_in = dev * dev;
   assign s4_vsq_in   = vofs * vofs;
   assign s4_low_in   = s3_temp_ff < TEMP_REF;
   assign s4_vlow_in  = s3_temp_ff <= TEMP_VLOW_MAX;
   assign ti_sel      = s4_low_in ? s3_tilo_ff : {4'b0, s3_tihi_ff};
   assign t_full      = s3_temp_ff - $signed({1'b0, ti_sel});

   always_comb begin
      priority if (t_full > 21'sd32767) begin
         s4_tsat_in = 16'sh7FFF;
      end else if (t_full < -21'sd32768) begin
         s4_tsat_in = 16'sh8000;
      end else begin
         s4_tsat_in = t_full[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_devsq_ff <= s4_devsq_in;
         s4_vsq_ff   <= s4_vsq_in;
         s4_low_ff   <= s4_low_in;
         s4_vlow_ff  <= s4_vlow_in;
         s4_tsat_ff  <= s4_tsat_in;
         s4_offs_ff  <= s3_offs_ff;
         s4_sens_ff  <= s3_sens_ff;
         s4_d1_ff    <= s3_d1_ff;
      end
   end

   // stage 5: offset and sensitivity corrections
   logic [39:0] dq, vq;
   logic [41:0] dev3, dev5;
   logic [42:0] v7;
   logic [39:0] s5_offi_in, s5_offi_ff, s5_sensi_in, s5_sensi_ff;
   logic signed [36:0] s5_offs_ff;
   logic signed [35:0] s5_sens_ff;
   logic signed [15:0] s5_tsat_ff;
   logic [23:0]        s5_d1_ff;

   assign dq   = s4_devsq_ff;
   assign vq   = s4_vsq_ff;
   assign dev3 = {2'b0, dq} + {1'b0, dq, 1'b0};
   assign dev5 = {2'b0, dq} + {dq, 2'b00};
   assign v7   = {vq, 3'b000} - {3'b000, vq};

   always_comb begin
      if (s4_low_ff) begin
         s5_offi_in  = dev3[40:1] + (s4_vlow_ff ? v7[39:0] : 40'd0);
         s5_sensi_in = {1'b0, dev5[41:3]} + (s4_vlow_ff ? {vq[37:0], 2'b00} : 40'd0);
      end else begin
         s5_offi_in  = {4'b0, dq[39:4]};
         s5_sensi_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_offi_ff  <= s5_offi_in;
         s5_sensi_ff <= s5_sensi_in;
         s5_offs_ff  <= s4_offs_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_tsat_ff  <= s4_tsat_ff;
         s5_d1_ff    <= s4_d1_ff;
      end
   end

   // stage 6: apply corrections
   logic signed [39:0] s6_offs_in, s6_offs_ff, s6_sens_in, s6_sens_ff;
   logic signed [15:0] s6_tsat_ff;
   logic [23:0]        s6_d1_ff;

   assign s6_offs_in = s5_offs_ff - $signed(s5_offi_ff);
   assign s6_sens_in = s5_sens_ff - $signed(s5_sensi_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s6_offs_ff <= s6_offs_in;
         s6_sens_ff <= s6_sens_in;
         s6_tsat_ff <= s5_tsat_ff;
         s6_d1_ff   <= s5_d1_ff;
      end
   end

   assign out_vld           = vld_ff[5];
   assign out_data.d1       = s6_d1_ff;
   assign out_data.offs     = s6_offs_ff;
   assign out_data.sens     = s6_sens_ff;
   assign out_data.temp_sat = s6_tsat_ff;

endmodule

// ===== src/ptdc_press.sv =====
// ----------------------------------------------------------------------------
// ptdc_press
// pressure product, scaling and divide by ten, eight stages
// ----------------------------------------------------------------------------
module ptdc_press import ptdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_vld,
   input  comp_type    in_data,
   input  logic [17:0] surf,
   output logic        out_vld,
   output press_type   out_data
);

   logic [7:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:0], in_vld};
      end
   end

   // stage 1: split D1*SENS into two partial products
   logic [43:0]        s1_lo_in, s1_lo_ff;
   logic signed [44:0] s1_hi_in, s1_hi_ff;
   logic signed [39:0] s1_offs_ff;
   logic signed [15:0] s1_tsat_ff;

   assign s1_lo_in = in_data.d1 * in_data.sens[19:0];
   assign s1_hi_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_lo_ff   <= s1_lo_in;
         s1_hi_ff   <= s1_hi_in;
         s1_offs_ff <= in_data.offs;
         s1_tsat_ff <= in_data.temp_sat;
      end
   end

   // stage 2: recombine
   logic signed [63:0] hi_ext;
   logic signed [63:0] s2_prod_in, s2_prod_ff;
   logic signed [39:0] s2_offs_ff;
   logic signed [15:0] s2_tsat_ff;

   assign hi_ext     = {{19{s1_hi_ff[44]}}, s1_hi_ff};
   assign s2_prod_in = $signed({hi_ext[43:0], 20'h00000}) + $signed({20'h00000, s1_lo_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         s2_prod_ff <= s2_prod_in;
         s2_offs_ff <= s1_offs_ff;
         s2_tsat_ff <= s1_tsat_ff;
      end
   end

   // stage 3: divide by 2^21 toward zero
   logic signed [63:0] prod_adj;
   logic signed [42:0] s3_a_ff;
   logic signed [39:0] s3_offs_ff;
   logic signed [15:0] s3_tsat_ff;

   assign prod_adj = s2_prod_ff + (s2_prod_ff[63] ? 64'sd2097151 : 64'sd0);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_a_ff    <= $signed(prod_adj[63:21]);
         s3_offs_ff <= s2_offs_ff;
         s3_tsat_ff <= s2_tsat_ff;
      end
   end

   // stage 4: subtract offset
   logic signed [43:0] s4_b_in, s4_b_ff;
   logic signed [15:0] s4_tsat_ff;

   assign s4_b_in = s3_a_ff - s3_offs_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_b_ff    <= s4_b_in;
         s4_tsat_ff <= s3_tsat_ff;
      end
   end

   // stage 5: magnitude over 2^13
   logic [43:0]        b_abs;
   logic [30:0]        s5_bmag_ff;
   logic               s5_neg_ff;
   logic signed [15:0] s5_tsat_ff;

   assign b_abs = s4_b_ff[43] ? 44'(-s4_b_ff) : 44'(s4_b_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s5_bmag_ff <= b_abs[43:13];
         s5_neg_ff  <= s4_b_ff[43];
         s5_tsat_ff <= s4_tsat_ff;
      end
   end

   // stage 6: reciprocal multiply for divide by ten
   logic [63:0]        s6_m_in, s6_m_ff;
   logic               s6_neg_ff;
   logic signed [15:0] s6_tsat_ff;

   assign s6_m_in = {1'b0, s5_bmag_ff} * RECIP_TEN;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_m_ff    <= s6_m_in;
         s6_neg_ff  <= s5_neg_ff;
         s6_tsat_ff <= s5_tsat_ff;
      end
   end

   // stage 7: signed pressure and its saturated form
   logic [28:0]        pmag;
   logic [16:0]        pm17;
   logic signed [29:0] s7_p_in, s7_p_ff;
   logic signed [16:0] s7_psat_in, s7_psat_ff;
   logic signed [15:0] s7_tsat_ff;

   assign pmag    = s6_m_ff[63:35];
   assign pm17    = pmag[16:0];
   assign s7_p_in = s6_neg_ff ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});

   always_comb begin
      if (s6_neg_ff) begin
         s7_psat_in = (pmag > 29'd65536) ? 17'sh10000 : $signed(17'd0 - pm17);
      end else begin
         s7_psat_in = (pmag > 29'd65535) ? 17'sh0FFFF : $signed(pm17);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_p_ff    <= s7_p_in;
         s7_psat_ff <= s7_psat_in;
         s7_tsat_ff <= s6_tsat_ff;
      end
   end

   // stage 8: pascal over surface
   logic signed [35:0] s8_x_in, s8_x_ff;
   logic signed [16:0] s8_psat_ff;
   logic signed [15:0] s8_tsat_ff;

   assign s8_x_in = s7_p_ff * 36'sd100 - $signed({18'b0, surf});

   always_ff @(posedge clock) begin
      if (en) begin
         s8_x_ff    <= s8_x_in;
         s8_psat_ff <= s7_psat_ff;
         s8_tsat_ff <= s7_tsat_ff;
      end
   end

   assign out_vld            = vld_ff[7];
   assign out_data.excess_pa = s8_x_ff;
   assign out_data.press_sat = s8_psat_ff;
   assign out_data.temp_sat  = s8_tsat_ff;

endmodule

// ===== src/ptdc_div.sv =====
// ----------------------------------------------------------------------------
// ptdc_div
// depth division, restoring radix-2 pipeline, one quotient bit per stage
// ----------------------------------------------------------------------------
module ptdc_div import ptdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_vld,
   input  press_type   in_data,
   input  logic [11:0] rho,
   output logic        out_vld,
   output div_type     out_data
);

   localparam int NSTG = QUOT_W + 3;
   localparam int REM_W = 32 + QUOT_W;

   logic [NSTG-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_vld};
      end
   end

   // stage 1: magnitude and divisor
   logic [35:0]        x_abs;
   logic [11:0]        rho_eff;
   logic [34:0]        s1_xmag_ff;
   logic [31:0]        s1_dvs_in, s1_dvs_ff;
   logic               s1_neg_ff;
   logic signed [16:0] s1_psat_ff;
   logic signed [15:0] s1_tsat_ff;

   assign x_abs     = in_data.excess_pa[35] ? 36'(-in_data.excess_pa) : 36'(in_data.excess_pa);
   assign rho_eff   = (rho == 12'd0) ? 12'd1 : rho;
   assign s1_dvs_in = rho_eff * GRAV_SCALE;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_xmag_ff <= x_abs[34:0];
         s1_dvs_ff  <= s1_dvs_in;
         s1_neg_ff  <= in_data.excess_pa[35];
         s1_psat_ff <= in_data.press_sat;
         s1_tsat_ff <= in_data.temp_sat;
      end
   end

   // stage 2: numerator
   logic [61:0]        s2_num_in, s2_num_ff;
   logic [31:0]        s2_dvs_ff;
   logic               s2_neg_ff;
   logic signed [16:0] s2_psat_ff;
   logic signed [15:0] s2_tsat_ff;

   assign s2_num_in = s1_xmag_ff * DEPTH_SCALE;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_num_ff  <= s2_num_in;
         s2_dvs_ff  <= s1_dvs_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_psat_ff <= s1_psat_ff;
         s2_tsat_ff <= s1_tsat_ff;
      end
   end

   // stage 3 feeds bit stages through index 0
   logic [REM_W-1:0]   rem_ff  [QUOT_W+1];
   logic [QUOT_W-1:0]  q_ff    [QUOT_W+1];
   logic [31:0]        dvs_ff  [QUOT_W+1];
   logic               neg_ff  [QUOT_W+1];
   logic               ovf_ff  [QUOT_W+1];
   logic signed [16:0] psat_ff [QUOT_W+1];
   logic signed [15:0] tsat_ff [QUOT_W+1];
   logic               ovf_in;

   // quotient beyond the output range saturates
   assign ovf_in = s2_num_ff >= {7'b0, s2_dvs_ff, {QUOT_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= s2_num_ff[REM_W-1:0];
         q_ff[0]    <= '0;
         dvs_ff[0]  <= s2_dvs_ff;
         neg_ff[0]  <= s2_neg_ff;
         ovf_ff[0]  <= ovf_in;
         psat_ff[0] <= s2_psat_ff;
         tsat_ff[0] <= s2_tsat_ff;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_bit
      localparam int SH = QUOT_W - 1 - k;
      logic [REM_W-1:0] sub_w;
      logic             ge_w;

      assign sub_w = REM_W'(dvs_ff[k]) << SH;
      assign ge_w  = rem_ff[k] >= sub_w;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge_w ? (rem_ff[k] - sub_w) : rem_ff[k];
            q_ff[k+1]    <= {q_ff[k][QUOT_W-2:0], ge_w};
            dvs_ff[k+1]  <= dvs_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            psat_ff[k+1] <= psat_ff[k];
            tsat_ff[k+1] <= tsat_ff[k];
         end
      end
   end

   assign out_vld            = vld_ff[NSTG-1];
   assign out_data.quot      = q_ff[QUOT_W];
   assign out_data.ovf       = ovf_ff[QUOT_W];
   assign out_data.neg       = neg_ff[QUOT_W];
   assign out_data.press_sat = psat_ff[QUOT_W];
   assign out_data.temp_sat  = tsat_ff[QUOT_W];

endmodule

// ===== src/pressure_temperature_depth_compensation_top.sv =====
// ----------------------------------------------------------------------------
// pressure temperature depth compensation top: second-order sensor compensation with depth
// pipeline: 41 register stages, mostly the 26-stage divider
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: synchronous active high, clears valid bits and loads calibration defaults
// ----------------------------------------------------------------------------
`include "pressure_temperature_depth_compensation_top_assert.svh"

module pressure_temperature_depth_compensation_top import ptdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // calibration and environment registers
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{surface_pressure_pa: SURF_RESET, fluid_density_kgm3: RHO_RESET,
                     default: '0};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_C1:   cfg_ff.coeff_sens_c1       <= csr_wdata[15:0];
            CSR_C2:   cfg_ff.coeff_off_c2        <= csr_wdata[15:0];
            CSR_C3:   cfg_ff.coeff_tcs_c3        <= csr_wdata[15:0];
            CSR_C4:   cfg_ff.coeff_tco_c4        <= csr_wdata[15:0];
            CSR_C5:   cfg_ff.coeff_tref_c5       <= csr_wdata[15:0];
            CSR_C6:   cfg_ff.coeff_tsens_c6      <= csr_wdata[15:0];
            CSR_SURF: cfg_ff.surface_pressure_pa <= csr_wdata;
            CSR_RHO:  cfg_ff.fluid_density_kgm3  <= csr_wdata[11:0];
         endcase
      end
   end

   // global advance: every stage moves when the output register is free or drained
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // front end: dT, first order terms, second order corrections
   logic     front_vld;
   comp_type front_data;

   ptdc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (req_valid),
      .in_data  (req_data),
      .cfg      (cfg_ff),
      .out_vld  (front_vld),
      .out_data (front_data)
   );

   // pressure in mbar and excess pascal over surface
   logic      press_vld;
   press_type press_data;

   ptdc_press u_press (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (front_vld),
      .in_data  (front_data),
      .surf     (cfg_ff.surface_pressure_pa),
      .out_vld  (press_vld),
      .out_data (press_data)
   );

   // depth division
   logic    div_vld;
   div_type div_data;

   ptdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (press_vld),
      .in_data  (press_data),
      .rho      (cfg_ff.fluid_density_kgm3),
      .out_vld  (div_vld),
      .out_data (div_data)
   );

   // sign and saturation of depth
   logic signed [23:0] depth_w;

   always_comb begin
      if (div_data.ovf) begin
         depth_w = div_data.neg ? 24'sh800000 : 24'sh7FFFFF;
      end else if (div_data.neg) begin
         depth_w = $signed(24'd0 - {1'b0, div_data.quot});
      end else begin
         depth_w = $signed({1'b0, div_data.quot});
      end
   end

   assign rsp_data_in.pressure_mbar     = div_data.press_sat;
   assign rsp_data_in.temperature_centi = div_data.temp_sat;
   assign rsp_data_in.depth_mm          = depth_w;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && div_vld) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks: pipeline freezes on stall, output register loads only real items
   logic [2:0] pipe_vld;
   assign pipe_vld = {front_vld, press_vld, div_vld};

   `PTDC_ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_valid && !rsp_ready, pipe_vld == $past(pipe_vld))
   `PTDC_ASSERT_NEXT(a_out_load, clock, reset, div_vld && req_ready, rsp_valid)
   `PTDC_ASSERT_NEXT(a_no_phantom, clock, reset, !div_vld && req_ready, !rsp_valid)
   `PTDC_ASSERT_NOW(a_ready_follows, clock, reset, rsp_valid && !rsp_ready, !req_ready)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: pressure temperature depth compensation testbench
// drives raw d1/d2 conversion pairs under several calibration sets, predicts
// compensated pressure, temperature and depth, and checks every result in order
// ----------------------------------------------------------------------------
module tb;
   import ptdc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // mirror of the calibration registers, updated after each full calibration load
   cfg_type cal;
   // compensated readings waiting for their result item, oldest first
   rsp_type pending_readings[$];
   int      mismatches;
   int      cycle_count;
   // quiet: no random idling on either side; hold_rsp: ask for a long stall
   bit      quiet;
   bit      hold_rsp;

   // directed stimulus row; typed rows carry a hand-derived result
   typedef struct {
      req_type sample;
      bit      typed;
      rsp_type want;
   } row_type;

   pressure_temperature_depth_compensation_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // second-order compensation, signed 64-bit, divisions truncate toward zero
   function automatic rsp_type compensate(req_type s, cfg_type c);
      longint d1, d2, dt, temp, offs, sens, ti, offi, sensi, dev, vlow;
      longint p, t, rho, depth;
      rsp_type r;
      d1 = longint'(s.raw_pressure_d1);
      d2 = longint'(s.raw_temperature_d2);
      dt = d2 - longint'(c.coeff_tref_c5) * 256;
      temp = 2000 + (dt * longint'(c.coeff_tsens_c6)) / 64'sd8388608;
      offs = longint'(c.coeff_off_c2) * 65536 + (longint'(c.coeff_tco_c4) * dt) / 128;
      sens = longint'(c.coeff_sens_c1) * 32768 + (longint'(c.coeff_tcs_c3) * dt) / 256;
      dev = temp - 2000;
      if (temp / 100 < 20) begin
         // low temperature branch
         ti = (3 * dt * dt) / 64'sd8589934592;
         offi = (3 * dev * dev) / 2;
         sensi = (5 * dev * dev) / 8;
         if (temp / 100 < -15) begin
            // very low temperature addition
            vlow = temp + 1500;
            offi += 7 * vlow * vlow;
            sensi += 4 * vlow * vlow;
         end
      end else begin
         ti = (2 * dt * dt) / 64'sd137438953472;
         offi = (dev * dev) / 16;
         sensi = 0;
      end
      offs -= offi;
      sens -= sensi;
      t = temp - ti;
      p = (((d1 * sens) / 2097152 - offs) / 8192) / 10;
      // zero density counts as one
      rho = (c.fluid_density_kgm3 == 0) ? 1 : longint'(c.fluid_density_kgm3);
      // depth from the unsaturated pressure
      depth = ((p * 100 - longint'(c.surface_pressure_pa)) * 64'sd100000000)
              / (rho * 64'sd980665);
      r.pressure_mbar     = 17'(clamp(p, -65536, 65535));
      r.temperature_centi = 16'(clamp(t, -32768, 32767));
      r.depth_mm          = 24'(clamp(depth, -8388608, 8388607));
      return r;
   endfunction

   function automatic int gap_cycles();
      if (quiet || $urandom_range(99) >= 23) return 0;
      return 1;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // load a full calibration set; only called with the pipeline empty
   task automatic load_calibration(cfg_type c);
      req_valid <= 1'b0;
      wait (pending_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_C1, 18'(c.coeff_sens_c1));
      write_reg(CSR_C2, 18'(c.coeff_off_c2));
      write_reg(CSR_C3, 18'(c.coeff_tcs_c3));
      write_reg(CSR_C4, 18'(c.coeff_tco_c4));
      write_reg(CSR_C5, 18'(c.coeff_tref_c5));
      write_reg(CSR_C6, 18'(c.coeff_tsens_c6));
      write_reg(CSR_SURF, 18'(c.surface_pressure_pa));
      write_reg(CSR_RHO, 18'(c.fluid_density_kgm3));
      csr_valid <= 1'b0;
      cal = c;
   endtask

   // offer one sample pair; the expected reading is queued at acceptance
   task automatic send_sample(req_type s, bit typed, rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      pending_readings.push_back(typed ? want : compensate(s, cal));
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type random_sample();
      req_type s;
      int      span;
      s.raw_pressure_d1 = 24'($urandom);
      if ($urandom_range(1)) begin
         s.raw_temperature_d2 = 24'($urandom);
      end else begin
         // around the reference temperature, where the branches switch
         span = 1 << $urandom_range(22, 8);
         s.raw_temperature_d2 = 24'(clamp(longint'(cal.coeff_tref_c5) * 256
                                + $urandom_range(2 * span) - span, 0, 24'hFFFFFF));
      end
      return s;
   endfunction

   function automatic cfg_type random_calibration();
      cfg_type c;
      c.coeff_sens_c1       = 16'($urandom);
      c.coeff_off_c2        = 16'($urandom);
      c.coeff_tcs_c3        = 16'($urandom);
      c.coeff_tco_c4        = 16'($urandom);
      c.coeff_tref_c5       = 16'($urandom);
      c.coeff_tsens_c6      = 16'($urandom);
      c.surface_pressure_pa = 18'($urandom);
      c.fluid_density_kgm3  = 12'($urandom_range(4095, 1));
      return c;
   endfunction

   // result side: checks every accepted item, stalls at random, long hold on request
   initial begin : result_side
      rsp_type got, want;
      int      held;
      rsp_ready <= 1'b0;
      held = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (pending_readings.size() == 0) begin
               $error("result item with no reading pending");
               mismatches++;
            end else begin
               want = pending_readings.pop_front();
               if (got.pressure_mbar !== want.pressure_mbar) begin
                  $error("pressure_mbar expected %0d got %0d",
                         want.pressure_mbar, got.pressure_mbar);
                  mismatches++;
               end
               if (got.temperature_centi !== want.temperature_centi) begin
                  $error("temperature_centi expected %0d got %0d",
                         want.temperature_centi, got.temperature_centi);
                  mismatches++;
               end
               if (got.depth_mm !== want.depth_mm) begin
                  $error("depth_mm expected %0d got %0d", want.depth_mm, got.depth_mm);
                  mismatches++;
               end
            end
         end
         if (hold_rsp && held < HOLD_CYCLES) begin
            // long hold so the pipeline fills and backs up the input
            held++;
            rsp_ready <= 1'b0;
         end else begin
            if (!hold_rsp) held = 0;
            rsp_ready <= quiet || ($urandom_range(99) >= 19);
         end
      end
   end

   initial begin : stimulus
      row_type   rows[$];
      row_type   r;
      cfg_type   c;
      cfg_type   sets[$];
      localparam rsp_type AT_RESET_COOL = '{17'sd0, 16'sd2000, -24'sd10038};
      localparam rsp_type AT_RESET_HOT  = '{17'sd0, -16'sd2095, -24'sd10038};
      mismatches  = 0;
      cycle_count = 0;
      quiet       = 1'b0;
      hold_rsp    = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_C1;
      csr_wdata   <= '0;
      cal = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, SURF_RESET, RHO_RESET};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: zero sensitivity, so pressure is zero and depth is
      // the surface offset alone; temperature falls with the square of d2
      rows.push_back('{'{24'd0, 24'd0}, 1'b1, AT_RESET_COOL});
      rows.push_back('{'{24'hFFFFFF, 24'd0}, 1'b1, AT_RESET_COOL});
      rows.push_back('{'{24'd0, 24'hFFFFFF}, 1'b1, AT_RESET_HOT});
      rows.push_back('{'{24'hFFFFFF, 24'hFFFFFF}, 1'b1, AT_RESET_HOT});
      foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].want);
      rows.delete();

      // typical calibration; d2 picks high, low and very low temperature
      c = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146,
            18'd101300, 12'd1029};
      load_calibration(c);
      r.typed = 1'b0;
      r.want  = '0;
      begin : typical_rows
         logic [23:0] temps[10];
         temps = '{24'd6821376, 24'd8000000, 24'd6500000, 24'd6000000, 24'd5540000,
                   24'd4000000, 24'd0, 24'hFFFFFF, 24'd6810000, 24'd6821377};
         foreach (temps[i]) begin
            r.sample.raw_temperature_d2 = temps[i];
            r.sample.raw_pressure_d1 = (i % 3 == 0) ? 24'hFFFFFF
                                     : (i % 3 == 1) ? 24'd0 : 24'd4958179;
            rows.push_back(r);
         end
      end
      foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].want);

      // random phases: typical, all zero with zero density, all maximum,
      // then random calibration sets
      sets.push_back(c);
      sets.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 18'd0, 12'd0});
      sets.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       18'h3FFFF, 12'hFFF});
      repeat (3) sets.push_back(random_calibration());
      foreach (sets[p]) begin
         load_calibration(sets[p]);
         quiet = (p == 1);
         for (int n = 0; n < 138; n++) begin
            if (p == 2 && n == 20) hold_rsp = 1'b1;
            if (p == 2 && n == 80) hold_rsp = 1'b0;
            // sender pause until every pending reading has come back
            if (p == 3 && n == 60) begin
               req_valid <= 1'b0;
               wait (pending_readings.size() == 0);
            end
            send_sample(random_sample(), 1'b0, '0);
         end
         quiet = 1'b0;
      end
      req_valid <= 1'b0;

      wait (pending_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/ptdc_pkg.sv
src/ptdc_front.sv
src/ptdc_press.sv
src/ptdc_div.sv
src/pressure_temperature_depth_compensation_top.sv
tb/sv/tb.sv
